>>> rtl/i2d_pkg.sv
// shared types and constants for the int64 to binary64 converter
package i2d_pkg;
    localparam int unsigned FracBits = 52;
    localparam int unsigned ExpBias  = 1023;
    typedef logic [63:0] t_word;
    typedef logic [5:0]  t_pos;
    typedef logic [10:0] t_exp;
endpackage

>>> rtl/i2d_lzc.sv
// leading one position of a nonzero 64-bit magnitude
module i2d_lzc (
    input  i2d_pkg::t_word i_mag,
    output i2d_pkg::t_pos  o_pos
);
    import i2d_pkg::*;

    logic [15:0] w_any;
    logic [1:0]  w_sub [16];
    logic [3:0]  w_grp;
    logic [3:0]  w_nib;

    always_comb begin
        for (int g = 0; g < 16; g++) begin
            w_nib    = i_mag[g*4 +: 4];
            w_any[g] = |w_nib;
            if (w_nib[3])      w_sub[g] = 2'd3;
            else if (w_nib[2]) w_sub[g] = 2'd2;
            else if (w_nib[1]) w_sub[g] = 2'd1;
            else               w_sub[g] = 2'd0;
        end
        w_grp = '0;
        for (int g = 0; g < 16; g++) begin
            if (w_any[g]) w_grp = 4'(g);
        end
        o_pos = {w_grp, w_sub[w_grp]};
    end
endmodule

>>> rtl/int64_to_double_convert_top.sv
// throughput: one transaction per cycle while the output is not stalled, set by the four-stage pipeline
// a stall holds every stage; an empty stage fills while downstream waits
// reset (synchronous, active low) clears the stage valid bits only
// stages: magnitude, leading one, normalize, round and pack
module int64_to_double_convert_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // value[63:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // result_bits[63:0]
);
    import i2d_pkg::*;

    logic [3:0] r_vld;
    logic [3:0] w_en;
    logic       r_s1_sign, r_s2_sign, r_s3_sign;
    logic       r_s1_zero, r_s2_zero, r_s3_zero;
    t_word      r_s1_mag, r_s2_mag;
    t_pos       r_s2_pos, r_s3_pos;
    t_pos       w_pos;
    logic [52:0] r_s3_sig;
    logic        r_s3_grd, r_s3_stk;
    t_word       r_out;
    t_word       n_norm;
    logic [53:0] n_sig;
    t_exp        n_exp;

    assign w_en[3] = !r_vld[3] || m_axis_tready;
    assign w_en[2] = !r_vld[2] || w_en[3];
    assign w_en[1] = !r_vld[1] || w_en[2];
    assign w_en[0] = !r_vld[0] || w_en[1];
    assign s_axis_tready = w_en[0];
    assign m_axis_tvalid = r_vld[3];
    assign m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= s_axis_tvalid;
            if (w_en[1]) r_vld[1] <= r_vld[0];
            if (w_en[2]) r_vld[2] <= r_vld[1];
            if (w_en[3]) r_vld[3] <= r_vld[2];
        end
    end

    i2d_lzc u_lzc (.i_mag(r_s1_mag), .o_pos(w_pos));

    always_comb begin
        n_norm = r_s2_mag << (6'd63 - r_s2_pos);
        n_sig  = {1'b0, r_s3_sig} + 54'(r_s3_grd && (r_s3_stk || r_s3_sig[0]));
        n_exp  = t_exp'(ExpBias) + t_exp'(r_s3_pos) + t_exp'(n_sig[53]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s1_sign <= s_axis_tdata[63];
            r_s1_zero <= ~|s_axis_tdata;
            r_s1_mag  <= s_axis_tdata[63] ? (~s_axis_tdata + 64'd1) : s_axis_tdata;
        end
        if (w_en[1]) begin
            r_s2_sign <= r_s1_sign;
            r_s2_zero <= r_s1_zero;
            r_s2_mag  <= r_s1_mag;
            r_s2_pos  <= w_pos;
        end
        if (w_en[2]) begin
            r_s3_sign <= r_s2_sign;
            r_s3_zero <= r_s2_zero;
            r_s3_pos  <= r_s2_pos;
            r_s3_sig  <= n_norm[63:11];
            r_s3_grd  <= n_norm[10];
            r_s3_stk  <= |n_norm[9:0];
        end
        if (w_en[3]) begin
            if (r_s3_zero) r_out <= '0;
            else r_out <= {r_s3_sign, n_exp, n_sig[53] ? n_sig[52:1] : n_sig[51:0]};
        end
    end
endmodule

>>> rtl/i2d_checker.sv
// port-level checks for the converter
module i2d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [63:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output free");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata == 64'd0 && m_axis_tready
        ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
        |=> m_axis_tvalid && m_axis_tdata == 64'd0)
        else $error("zero input gave nonzero result");
    a_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
endmodule

bind int64_to_double_convert_top i2d_checker u_chk (.*);
